FILE: design/ddo_pkg.sv
// Shared types, constants and the CORDIC angle table for the odometry block.
// No dependencies.
package ddo_pkg;

  localparam int CountBitsDef   = 24;
  localparam int CordicStepsDef = 24;

  localparam logic [29:0]        BamPerRad  = 30'd683565276;
  localparam logic signed [34:0] CordicX0   = 35'sd652032874;
  localparam logic [15:0]        CpcReset   = 16'd2934;
  localparam logic [15:0]        TwReset    = 16'd5760;

  typedef enum logic [1:0] {
    CFG_COUNTS_PER_CM = 2'd0,
    CFG_TRACK_WIDTH   = 2'd1
  } cfg_reg_e;

  typedef struct packed {
    logic signed [23:0] left_count;
    logic signed [23:0] right_count;
  } odo_in_t;

  typedef struct packed {
    logic signed [31:0] step_dx;
    logic signed [31:0] step_dy;
    logic signed [39:0] pos_x;
    logic signed [39:0] pos_y;
    logic [31:0]        heading;
  } odo_out_t;

  typedef enum logic [3:0] {
    S_IDLE, S_DIVL, S_DIVR, S_MULQ, S_DIVQ, S_TRIG1, S_MULR, S_DIVRAD,
    S_TRIG2, S_MX0, S_MX1, S_MY0, S_MY1, S_MFIN, S_DONE
  } back_state_e;

  function automatic logic [29:0] atan_bam(input logic [4:0] i);
    logic [29:0] v;
    unique case (i)
      5'd0:  v = 30'd536870912;
      5'd1:  v = 30'd316933406;
      5'd2:  v = 30'd167458907;
      5'd3:  v = 30'd85004756;
      5'd4:  v = 30'd42667331;
      5'd5:  v = 30'd21354465;
      5'd6:  v = 30'd10679838;
      5'd7:  v = 30'd5340245;
      5'd8:  v = 30'd2670163;
      5'd9:  v = 30'd1335087;
      5'd10: v = 30'd667544;
      5'd11: v = 30'd333772;
      5'd12: v = 30'd166886;
      5'd13: v = 30'd83443;
      5'd14: v = 30'd41722;
      5'd15: v = 30'd20861;
      5'd16: v = 30'd10430;
      5'd17: v = 30'd5215;
      5'd18: v = 30'd2608;
      5'd19: v = 30'd1304;
      5'd20: v = 30'd652;
      5'd21: v = 30'd326;
      5'd22: v = 30'd163;
      5'd23: v = 30'd81;
      5'd24: v = 30'd41;
      5'd25: v = 30'd20;
      5'd26: v = 30'd10;
      5'd27: v = 30'd5;
      5'd28: v = 30'd3;
      5'd29: v = 30'd1;
      5'd30: v = 30'd1;
      5'd31: v = 30'd0;
    endcase
    return v;
  endfunction

endpackage

FILE: design/differential_drive_odometry.sv
// Differential-drive odometry. The back end takes one item at a time from the queue and runs
// three divisions and one CORDIC pass on a straight step, four divisions and two on an arc,
// then offers the result at the output and holds it there until the output is free.
// A two-entry queue lets the input accept up to two more items meanwhile.
// Asynchronous active-low reset clears the pose, the last counts and the registers to defaults.
module differential_drive_odometry import ddo_pkg::*; #(
  parameter int COUNT_BITS   = CountBitsDef,
  parameter int CORDIC_STEPS = CordicStepsDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  odo_in_t     in_data_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output odo_out_t    out_data_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i
);

  logic [15:0]             cpc_q, tw_q;
  logic                    push, pop, full, empty;
  logic [2*COUNT_BITS-1:0] push_data, pop_data;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cpc_q <= CpcReset;
      tw_q  <= TwReset;
    end else if (cfg_valid_i) begin
      if (cfg_index_i == CFG_COUNTS_PER_CM) cpc_q <= cfg_data_i;
      if (cfg_index_i == CFG_TRACK_WIDTH) tw_q <= cfg_data_i;
    end
  end

  ddo_front #(.COUNT_BITS(COUNT_BITS)) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .full_i     (full),
    .push_o     (push),
    .push_data_o(push_data)
  );

  ddo_queue #(.WIDTH(2*COUNT_BITS)) u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_data_i(push_data),
    .pop_i      (pop),
    .pop_data_o (pop_data),
    .full_o     (full),
    .empty_o    (empty)
  );

  ddo_back #(.COUNT_BITS(COUNT_BITS), .CORDIC_STEPS(CORDIC_STEPS)) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .empty_i    (empty),
    .pop_o      (pop),
    .pop_data_i (pop_data),
    .cpc_i      (cpc_q),
    .tw_i       (tw_q),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

endmodule

FILE: design/ddo_front.sv
// Front end: accepts encoder items, keeps the last counts and forms wrapped deltas.
// Depends on ddo_pkg.
module ddo_front import ddo_pkg::*; #(
  parameter int COUNT_BITS = CountBitsDef
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  odo_in_t                 in_data_i,
  input  logic                    full_i,
  output logic                    push_o,
  output logic [2*COUNT_BITS-1:0] push_data_o
);

  logic [COUNT_BITS-1:0] last_l_q, last_r_q, cur_l, cur_r;

  assign in_ready_o  = !full_i;
  assign push_o      = in_valid_i && in_ready_o;
  assign cur_l       = COUNT_BITS'($unsigned(in_data_i.left_count));
  assign cur_r       = COUNT_BITS'($unsigned(in_data_i.right_count));
  assign push_data_o = {cur_l - last_l_q, cur_r - last_r_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_l_q <= '0;
      last_r_q <= '0;
    end else if (push_o) begin
      last_l_q <= cur_l;
      last_r_q <= cur_r;
    end
  end

endmodule

FILE: design/ddo_queue.sv
// Two-entry queue between front and back end.
// No package dependencies.
module ddo_queue #(
  parameter int WIDTH = 48
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] push_data_i,
  input  logic             pop_i,
  output logic [WIDTH-1:0] pop_data_o,
  output logic             full_o,
  output logic             empty_o
);

  logic [WIDTH-1:0] mem_q [2];
  logic             wptr_q, rptr_q;
  logic [1:0]       cnt_q;

  assign full_o     = cnt_q == 2'd2;
  assign empty_o    = cnt_q == 2'd0;
  assign pop_data_o = mem_q[rptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      if (push_i) begin
        wptr_q <= !wptr_q;
      end
      if (pop_i) begin
        rptr_q <= !rptr_q;
      end
      cnt_q <= cnt_q + {1'b0, push_i} - {1'b0, pop_i};
    end
  end

endmodule

FILE: design/ddo_div.sv
// Restoring divider, one quotient bit per cycle, sign applied at the output.
// No package dependencies.
module ddo_div (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic [63:0]        num_i,
  input  logic [63:0]        den_i,
  input  logic               neg_i,
  output logic               busy_o,
  output logic signed [63:0] quot_o
);

  logic [64:0] rem_q, rem_sh;
  logic [63:0] quo_q, den_q;
  logic        neg_q, bit_set;
  logic [6:0]  cnt_q;

  assign busy_o  = cnt_q != 7'd0;
  assign rem_sh  = {rem_q[63:0], quo_q[63]};
  assign bit_set = rem_sh >= {1'b0, den_q};
  assign quot_o  = neg_q ? -$signed(quo_q) : $signed(quo_q);

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= num_i;
      den_q <= den_i;
      neg_q <= neg_i;
    end else if (busy_o) begin
      rem_q <= bit_set ? rem_sh - {1'b0, den_q} : rem_sh;
      quo_q <= {quo_q[62:0], bit_set};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 7'd0;
    end else if (start_i) begin
      cnt_q <= 7'd64;
    end else if (busy_o) begin
      cnt_q <= cnt_q - 7'd1;
    end
  end

endmodule

FILE: design/ddo_back.sv
// Back end: scaling, heading and radius divisions, CORDIC, products, pose update.
// Depends on ddo_pkg and ddo_div.
module ddo_back import ddo_pkg::*; #(
  parameter int COUNT_BITS   = CountBitsDef,
  parameter int CORDIC_STEPS = CordicStepsDef
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    empty_i,
  output logic                    pop_o,
  input  logic [2*COUNT_BITS-1:0] pop_data_i,
  input  logic [15:0]             cpc_i,
  input  logic [15:0]             tw_i,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output odo_out_t                out_data_o
);

  localparam int CiW = $clog2(CORDIC_STEPS);

  back_state_e state_q, state_d;

  logic signed [COUNT_BITS-1:0] sdr_q;
  logic signed [31:0]           dl_q, dr_q, dx_q, dy_q;
  logic signed [63:0]           q_q, r_q;
  logic signed [34:0]           cx_q, cy_q, cz_q, s1_q, c1_q, s2_q, c2_q;
  logic [CiW-1:0]               ci_q;
  logic                         flip_q;
  logic [68:0]                  plo_q, phi_q;
  logic [31:0]                  heading_q;
  logic signed [39:0]           x_q, y_q;
  odo_out_t                     out_q;
  logic                         out_valid_q;

  logic               div_start, div_busy, div_neg;
  logic [63:0]        div_num, div_den;
  logic signed [63:0] div_quot;
  logic [32:0]        mul_a;
  logic [35:0]        mul_b;
  logic [68:0]        mul_p;

  logic signed [32:0] sdiff, ssum;
  logic [32:0]        adiff, asum;
  logic [15:0]        cpc_eff, tw_eff;
  logic signed [63:0] sdr_ext, a_val;
  logic [63:0]        ua;
  logic signed [35:0] bx_val, by_val;
  logic [35:0]        ubx, uby;
  logic               negx, negy, cord_last, out_free;
  logic signed [34:0] xs, ys, cx_n, cy_n, cz_n, s_n, c_n;
  logic [31:0]        ang2;
  logic signed [40:0] xsum, ysum;

  ddo_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(div_start),
    .num_i  (div_num),
    .den_i  (div_den),
    .neg_i  (div_neg),
    .busy_o (div_busy),
    .quot_o (div_quot)
  );

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    logic signed [31:0] r;
    if (v > 64'sd2147483647) r = 32'sh7fffffff;
    else if (v < -64'sd2147483648) r = 32'sh80000000;
    else r = v[31:0];
    return r;
  endfunction

  function automatic logic signed [39:0] sat40(input logic signed [40:0] v);
    logic signed [39:0] r;
    if (v > 41'sd549755813887) r = 40'sh7fffffffff;
    else if (v < -41'sd549755813888) r = 40'sh8000000000;
    else r = v[39:0];
    return r;
  endfunction

  function automatic logic signed [31:0] q30_join(input logic [68:0] phi,
                                                  input logic [68:0] plo,
                                                  input logic neg);
    logic [40:0]        mag;
    logic signed [31:0] r;
    if (|phi[68:30]) mag = 41'h100000000;
    else mag = {9'd0, phi[29:0], 2'b00} + {2'd0, plo[68:30]};
    if (mag >= 41'h80000000) r = neg ? 32'sh80000000 : 32'sh7fffffff;
    else r = neg ? -$signed(mag[31:0]) : $signed(mag[31:0]);
    return r;
  endfunction

  assign cpc_eff = (cpc_i == 16'd0) ? 16'd1 : cpc_i;
  assign tw_eff  = (tw_i == 16'd0) ? 16'd1 : tw_i;
  assign sdr_ext = 64'(sdr_q);
  assign sdiff   = {dl_q[31], dl_q} - {dr_q[31], dr_q};
  assign ssum    = {dl_q[31], dl_q} + {dr_q[31], dr_q};
  assign adiff   = sdiff[32] ? 33'(-sdiff) : sdiff;
  assign asum    = ssum[32] ? 33'(-ssum) : ssum;
  assign mul_p   = 69'(mul_a) * 69'(mul_b);

  assign a_val  = (q_q == 64'sd0) ? 64'(dr_q) : r_q;
  assign ua     = a_val[63] ? 64'(-a_val) : a_val;
  assign bx_val = (q_q == 64'sd0) ? 36'(s1_q) : 36'(c1_q) - 36'(c2_q);
  assign by_val = (q_q == 64'sd0) ? 36'(c1_q) : 36'(s2_q) - 36'(s1_q);
  assign ubx    = bx_val[35] ? 36'(-bx_val) : bx_val;
  assign uby    = by_val[35] ? 36'(-by_val) : by_val;
  assign negx   = a_val[63] != bx_val[35];
  assign negy   = a_val[63] != by_val[35];

  assign xs        = cx_q >>> ci_q;
  assign ys        = cy_q >>> ci_q;
  assign cx_n      = cz_q[34] ? cx_q + ys : cx_q - ys;
  assign cy_n      = cz_q[34] ? cy_q - xs : cy_q + xs;
  assign cz_n      = cz_q[34] ? cz_q + 35'(atan_bam(5'(ci_q)))
                              : cz_q - 35'(atan_bam(5'(ci_q)));
  assign s_n       = flip_q ? -cy_n : cy_n;
  assign c_n       = flip_q ? -cx_n : cx_n;
  assign cord_last = ci_q == CiW'(CORDIC_STEPS - 1);
  assign ang2      = heading_q + q_q[31:0];
  assign out_free  = !out_valid_q || out_ready_i;
  assign xsum      = 41'(x_q) + 41'(dx_q);
  assign ysum      = 41'(y_q) + 41'(dy_q);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:   if (!empty_i) state_d = S_DIVL;
      S_DIVL:   if (!div_busy) state_d = S_DIVR;
      S_DIVR:   if (!div_busy) state_d = S_MULQ;
      S_MULQ:   state_d = S_DIVQ;
      S_DIVQ:   if (!div_busy) state_d = S_TRIG1;
      S_TRIG1:  if (cord_last) state_d = (q_q == 64'sd0) ? S_MX0 : S_MULR;
      S_MULR:   state_d = S_DIVRAD;
      S_DIVRAD: if (!div_busy) state_d = S_TRIG2;
      S_TRIG2:  if (cord_last) state_d = S_MX0;
      S_MX0:    state_d = S_MX1;
      S_MX1:    state_d = S_MY0;
      S_MY0:    state_d = S_MY1;
      S_MY1:    state_d = S_MFIN;
      S_MFIN:   state_d = S_DONE;
      S_DONE:   if (out_free) state_d = S_IDLE;
      default:  state_d = S_IDLE;
    endcase
  end

  always_comb begin
    pop_o     = 1'b0;
    div_start = 1'b0;
    div_num   = '0;
    div_den   = {48'd0, cpc_eff};
    div_neg   = 1'b0;
    mul_a     = adiff;
    mul_b     = 36'(BamPerRad);
    unique case (state_q)
      S_IDLE: begin
        pop_o     = !empty_i;
        div_start = !empty_i;
        div_neg   = pop_data_i[2*COUNT_BITS-1];
        div_num   = 64'(pop_data_i[2*COUNT_BITS-1]
                        ? -64'($signed(pop_data_i[2*COUNT_BITS-1:COUNT_BITS]))
                        : 64'($signed(pop_data_i[2*COUNT_BITS-1:COUNT_BITS]))) << 24;
      end
      S_DIVL: begin
        div_start = !div_busy;
        div_neg   = sdr_q[COUNT_BITS-1];
        div_num   = (sdr_q[COUNT_BITS-1] ? 64'(-sdr_ext) : sdr_ext) << 24;
      end
      S_MULQ: begin
        div_start = 1'b1;
        div_num   = mul_p[63:0];
        div_den   = {40'd0, tw_eff, 8'd0};
        div_neg   = sdiff[32];
      end
      S_MULR: begin
        mul_a     = asum;
        div_start = 1'b1;
        div_num   = mul_p[63:0];
        div_den   = (q_q[63] ? 64'(-q_q) : q_q) << 1;
        div_neg   = ssum[32] != q_q[63];
      end
      S_MX0: begin
        mul_a = {1'b0, ua[31:0]};
        mul_b = ubx;
      end
      S_MX1: begin
        mul_a = {1'b0, ua[63:32]};
        mul_b = ubx;
      end
      S_MY0: begin
        mul_a = {1'b0, ua[31:0]};
        mul_b = uby;
      end
      S_MY1: begin
        mul_a = {1'b0, ua[63:32]};
        mul_b = uby;
      end
      default: begin
        pop_o = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      S_IDLE: begin
        sdr_q <= pop_data_i[COUNT_BITS-1:0];
      end
      S_DIVL: if (!div_busy) dl_q <= sat32(div_quot);
      S_DIVR: if (!div_busy) dr_q <= sat32(div_quot);
      S_DIVQ: begin
        q_q    <= div_quot;
        cx_q   <= CordicX0;
        cy_q   <= '0;
        cz_q   <= 35'($signed({heading_q[30], heading_q[30:0]}));
        flip_q <= heading_q[31] ^ heading_q[30];
        ci_q   <= '0;
      end
      S_TRIG1: begin
        cx_q <= cx_n;
        cy_q <= cy_n;
        cz_q <= cz_n;
        ci_q <= ci_q + CiW'(1);
        if (cord_last) begin
          s1_q <= s_n;
          c1_q <= c_n;
        end
      end
      S_DIVRAD: begin
        r_q    <= div_quot;
        cx_q   <= CordicX0;
        cy_q   <= '0;
        cz_q   <= 35'($signed({ang2[30], ang2[30:0]}));
        flip_q <= ang2[31] ^ ang2[30];
        ci_q   <= '0;
      end
      S_TRIG2: begin
        cx_q <= cx_n;
        cy_q <= cy_n;
        cz_q <= cz_n;
        ci_q <= ci_q + CiW'(1);
        if (cord_last) begin
          s2_q <= s_n;
          c2_q <= c_n;
        end
      end
      S_MX0: plo_q <= mul_p;
      S_MX1: phi_q <= mul_p;
      S_MY0: begin
        dx_q  <= q30_join(phi_q, plo_q, negx);
        plo_q <= mul_p;
      end
      S_MY1: phi_q <= mul_p;
      S_MFIN: dy_q <= q30_join(phi_q, plo_q, negy);
      S_DONE: begin
        if (out_free) begin
          out_q.step_dx <= dx_q;
          out_q.step_dy <= dy_q;
          out_q.pos_x   <= sat40(xsum);
          out_q.pos_y   <= sat40(ysum);
          out_q.heading <= ang2;
        end
      end
      default: begin
        plo_q <= plo_q;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      heading_q   <= '0;
      x_q         <= '0;
      y_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == S_DONE && out_free) begin
        heading_q   <= ang2;
        x_q         <= sat40(xsum);
        y_q         <= sat40(ysum);
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

FILE: design/ddo_chk.sv
// Port-level checker for the odometry block, bound to the top level.
// Depends on ddo_pkg.
module ddo_chk import ddo_pkg::*; (
  input logic     clk_i,
  input logic     rst_ni,
  input logic     in_valid_i,
  input logic     in_ready_o,
  input logic     out_valid_o,
  input logic     out_ready_i,
  input odo_out_t out_data_o
);

  logic [2:0] pend_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= 3'd0;
    end else begin
      pend_q <= pend_q + {2'd0, in_valid_i && in_ready_o}
                       - {2'd0, out_valid_o && out_ready_i};
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o) else $error("output item dropped");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(out_data_o)) else $error("output item changed");

  a_no_invent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> pend_q != 3'd0) else $error("result without an item");

  a_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q <= 3'd4) else $error("too many items in flight");

endmodule

bind differential_drive_odometry ddo_chk u_ddo_chk (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_valid_i (in_valid_i),
  .in_ready_o (in_ready_o),
  .out_valid_o(out_valid_o),
  .out_ready_i(out_ready_i),
  .out_data_o (out_data_o)
);
